/* rtl/sha256_pkg.sv */
// sha256_pkg: shared types, constants and round functions for the sha-256 byte hasher
// no dependencies
package sha256_pkg;

  typedef enum logic [2:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_UPDATE,
    CORE_EMIT
  } core_state_t;

  // queued item from the front part
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } item_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = 1;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

/* rtl/sha256_queue.sv */
// sha256_queue: two-entry item queue between the input front and the compression back
// depends on sha256_pkg
module sha256_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sha256_pkg::item_t   wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sha256_pkg::item_t   rd_item
);

  sha256_pkg::item_t store_r [sha256_pkg::QUEUE_DEPTH];
  logic [sha256_pkg::QUEUE_AW-1:0] wptr_r, rptr_r;
  logic [sha256_pkg::QUEUE_AW:0]   count_r;
  logic do_wr, do_rd;

  assign wr_ready = (count_r != 2'(sha256_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = store_r[rptr_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 1'b1;
      if (do_rd) rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (do_wr) store_r[wptr_r] <= wr_item;
  end

endmodule

/* rtl/sha256_core.sv */
// sha256_core: byte buffering, padding, 64-round compression and digest output
// depends on sha256_pkg
module sha256_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  sha256_pkg::item_t item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_word,
  output logic [1:0]        out_index,
  output logic              out_last
);

  sha256_pkg::core_state_t state_r, state_nxt;

  logic [31:0]  wbuf_r [16];       // block words, reused as schedule window
  logic [5:0]   fill_r;            // bytes in block
  logic [63:0]  total_r;
  logic [255:0] chain_r;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]   round_r;
  logic [1:0]   emit_r;
  logic         pad_pend_r;        // second pass of padding still due
  logic         len_pend_r;        // message ended on a block edge: 0x80 leads the next block
  logic         end_pend_r;        // emit after this compression

  logic [31:0] w_t, s0, s1, t1, t2, bs0, bs1, ch, mj, w15, w2;
  logic        take;
  logic [63:0] bit_len;

  assign take = item_valid && item_ready;
  assign item_ready = (state_r == sha256_pkg::CORE_IDLE) && !pad_pend_r;
  assign bit_len = total_r << 3;

  // message schedule and round function
  always_comb begin
    w15 = wbuf_r[1];
    w2  = wbuf_r[14];
    s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    w_t = (round_r < 6'd16) ? wbuf_r[0] : (wbuf_r[0] + s0 + wbuf_r[9] + s1);
    bs1 = sha256_pkg::rotr(e_r, 6) ^ sha256_pkg::rotr(e_r, 11) ^ sha256_pkg::rotr(e_r, 25);
    ch  = (e_r & f_r) ^ (~e_r & g_r);
    t1  = h_r + bs1 + ch + sha256_pkg::round_k(round_r) + w_t;
    bs0 = sha256_pkg::rotr(a_r, 2) ^ sha256_pkg::rotr(a_r, 13) ^ sha256_pkg::rotr(a_r, 22);
    mj  = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2  = bs0 + mj;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256_pkg::CORE_IDLE: begin
        if (pad_pend_r) state_nxt = sha256_pkg::CORE_ROUND;
        else if (take && ((item.byte_valid && fill_r == 6'd63) || item.message_end))
          state_nxt = sha256_pkg::CORE_ROUND;
      end
      sha256_pkg::CORE_ROUND:
        if (round_r == 6'd63) state_nxt = sha256_pkg::CORE_UPDATE;
      sha256_pkg::CORE_UPDATE:
        if (pad_pend_r) state_nxt = sha256_pkg::CORE_IDLE;
        else if (end_pend_r) state_nxt = sha256_pkg::CORE_EMIT;
        else state_nxt = sha256_pkg::CORE_IDLE;
      sha256_pkg::CORE_EMIT:
        if (out_ready && emit_r == 2'd3) state_nxt = sha256_pkg::CORE_IDLE;
      default: state_nxt = sha256_pkg::CORE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = (state_r == sha256_pkg::CORE_EMIT);
    out_word  = chain_r[255 - 64*emit_r -: 64];
    out_index = emit_r;
    out_last  = (emit_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sha256_pkg::CORE_IDLE;
    else state_r <= state_nxt;
  end

  // datapath and control counters
  always_ff @(posedge clk) begin
    logic [5:0]  pos;
    logic [31:0] wd;
    logic [63:0] len_v;
    if (!rst_n) begin
      fill_r     <= '0;
      total_r    <= '0;
      chain_r    <= sha256_pkg::IV;
      round_r    <= '0;
      emit_r     <= '0;
      pad_pend_r <= 1'b0;
      len_pend_r <= 1'b0;
      end_pend_r <= 1'b0;
    end else begin
      case (state_r)
        sha256_pkg::CORE_IDLE: begin
          if (pad_pend_r) begin
            // length block, led by 0x80 when the message filled its last block
            wbuf_r[0] <= len_pend_r ? {sha256_pkg::PAD_BYTE, 24'd0} : 32'd0;
            for (int i = 1; i < 14; i++) wbuf_r[i] <= '0;
            wbuf_r[14] <= bit_len[63:32];
            wbuf_r[15] <= bit_len[31:0];
            pad_pend_r <= 1'b0;
            len_pend_r <= 1'b0;
            end_pend_r <= 1'b1;
          end else if (take) begin
            pos = fill_r + {5'd0, item.byte_valid};
            len_v = (total_r + {63'd0, item.byte_valid}) << 3;
            if (item.byte_valid) total_r <= total_r + 64'd1;
            if (item.message_end && !(item.byte_valid && fill_r == 6'd63)) begin
              // pad in place: byte, 0x80, zeros, then length if it fits
              for (int i = 0; i < 16; i++) begin
                wd = wbuf_r[i];
                if (item.byte_valid && 4'(i) == fill_r[5:2])
                  wd[31 - 8*fill_r[1:0] -: 8] = item.data_byte;
                if (4'(i) > pos[5:2]) begin
                  wd = '0;
                end else if (4'(i) == pos[5:2]) begin
                  wd = wd & ~(32'hffffffff >> (8*pos[1:0]));
                  wd[31 - 8*pos[1:0] -: 8] = sha256_pkg::PAD_BYTE;
                end
                if (pos < sha256_pkg::LEN_POS && i == 14) wd = len_v[63:32];
                if (pos < sha256_pkg::LEN_POS && i == 15) wd = len_v[31:0];
                wbuf_r[i] <= wd;
              end
              pad_pend_r <= (pos >= sha256_pkg::LEN_POS);
              end_pend_r <= (pos < sha256_pkg::LEN_POS);
              fill_r <= '0;
            end else begin
              if (item.byte_valid) begin
                wd = wbuf_r[fill_r[5:2]];
                wd[31 - 8*fill_r[1:0] -: 8] = item.data_byte;
                wbuf_r[fill_r[5:2]] <= wd;
              end
              // pos wraps to zero when the byte completes the block
              fill_r <= pos;
              len_pend_r <= item.message_end;
              end_pend_r <= 1'b0;
            end
          end
          {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= chain_r;
          round_r <= '0;
        end
        sha256_pkg::CORE_ROUND: begin
          for (int i = 0; i < 15; i++) wbuf_r[i] <= wbuf_r[i+1];
          wbuf_r[15] <= w_t;
          h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          round_r <= round_r + 6'd1;
        end
        sha256_pkg::CORE_UPDATE: begin
          chain_r <= {chain_r[255:224] + a_r, chain_r[223:192] + b_r,
                      chain_r[191:160] + c_r, chain_r[159:128] + d_r,
                      chain_r[127:96] + e_r, chain_r[95:64] + f_r,
                      chain_r[63:32] + g_r, chain_r[31:0] + h_r};
          // message ended exactly on a block edge: 0x80 block with length follows
          if (len_pend_r) pad_pend_r <= 1'b1;
          emit_r <= '0;
        end
        sha256_pkg::CORE_EMIT: begin
          if (out_ready) begin
            emit_r <= emit_r + 2'd1;
            if (emit_r == 2'd3) begin
              chain_r    <= sha256_pkg::IV;
              total_r    <= '0;
              end_pend_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// sha256_byte_stream_hasher: top level, input queue feeding the sha-256 core
// depends on sha256_pkg, sha256_queue, sha256_core
//
// usage: in_valid/in_ready carry one item (data_byte, byte_valid, message_end).
// a two-entry queue takes items while the core works. the core packs bytes into
// a 64-byte block; a full block, or a message end, runs 64 rounds, one per cycle,
// plus the chaining add. a byte that fills no block is only stored; the core stays
// idle and ready for the next item.
// on message end the block is padded; if the length does not fit a second
// block is compressed. four 64-bit digest words then leave on out_valid/
// out_ready, word 0 first, out_last_word on the fourth; the core holds while
// the receiver stalls, and the queue keeps accepting until full.
// after the last word the chaining value and byte count return to start values.
// reset (rst_n low, synchronous) empties the queue and restarts the message.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{data_byte: in_data_byte, byte_valid: in_byte_valid,
                     message_end: in_message_end};

  sha256_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sha256_core u_core (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_digest_word),
    .out_index(out_word_index), .out_last(out_last_word)
  );

  // last flag only on the fourth word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last flag mismatch");

  // word index steps by one after each taken word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=> (out_valid &&
      out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word order broken");

  // core takes no item while emitting
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_ready)
    else $error("item taken during digest output");

endmodule
